### rtl/core/spatial_hash_grid_builder_defines.svh
// Assertion macros for the spatial hash grid builder.
// Used by modules that assert; they expect clk and rst_n in scope.
`ifndef SPATIAL_HASH_GRID_BUILDER_DEFINES_SVH
`define SPATIAL_HASH_GRID_BUILDER_DEFINES_SVH

// ante implies cons in the same cycle
`define SHGB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// ante implies cons in the next cycle
`define SHGB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/shgb_pkg.sv
// Shared types and constants of the spatial hash grid builder.
// No dependencies.
`default_nettype none

package shgb_pkg;

    localparam int MAX_PARTICLES = 4096;
    localparam int IDX_W         = 12;
    localparam int CNT_W         = 13;

    localparam logic [CNT_W-1:0] BKT_LAST = 13'd4096;

    localparam logic [31:0] HASH_A = 32'd73856093;
    localparam logic [31:0] HASH_B = 32'd19349663;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_LONG  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;
    localparam logic [1:0] STAT_SHORT = 2'd3;

    localparam logic CFG_PCOUNT = 1'b0;
    localparam logic CFG_INV    = 1'b1;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_MUL_X,
        OP_MUL_Y,
        OP_MUL_A,
        OP_MUL_B,
        OP_HASH,
        OP_STORE,
        OP_Q_RD0,
        OP_Q_RD1,
        OP_Q_FIN,
        OP_E_RD,
        OP_E_FIN,
        OP_CLR,
        OP_CNT_RD,
        OP_CNT_DIV,
        OP_CNT_BRD,
        OP_CNT_BWR,
        OP_PRE_RD,
        OP_PRE_WR,
        OP_SC_RD,
        OP_SC_BRD,
        OP_SC_WR,
        OP_BUILT,
        OP_OUT
    } op_t;

    typedef struct packed {
        logic    div_done;
        logic    load_full;
        logic    in_last;
        action_t in_act;
        logic    item_last;
        action_t item_act;
        logic    clr_last;
        logic    cnt_empty;
        logic    cnt_last;
        logic    pre_last;
        logic    out_busy;
    } stat_t;

endpackage

`default_nettype wire

### rtl/core/shgb_mod_div.sv
// Iterative remainder unit: 32-bit dividend mod 13-bit divisor, one bit per cycle.
// Depends on shgb_pkg.
`default_nettype none

module shgb_mod_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [31:0]                  dividend,
    input  logic [shgb_pkg::CNT_W-1:0]   divisor,
    output logic                         busy,
    output logic                         done,
    output logic [shgb_pkg::IDX_W-1:0]   rem
);

    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;
    logic [4:0]                 cnt_reg, cnt_next;
    logic [31:0]                q_reg, q_next;
    logic [shgb_pkg::CNT_W-1:0] r_reg, r_next;
    logic [shgb_pkg::CNT_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        trial     = {r_reg, q_reg[31]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd31;
            q_next    = dividend;
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
                r_next = shgb_pkg::CNT_W'(trial - {1'b0, divisor});
            else
                r_next = trial[shgb_pkg::CNT_W-1:0];
            q_next   = {q_reg[30:0], 1'b0};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign rem  = r_reg[shgb_pkg::IDX_W-1:0];

endmodule

`default_nettype wire

### rtl/core/shgb_datapath.sv
// Datapath: config registers, multiplier, stores, counters and result register.
// Depends on shgb_pkg, shgb_mod_div and the assertion macro header.
`default_nettype none
`include "spatial_hash_grid_builder_defines.svh"

module shgb_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [23:0]         cfg_wdata,
    input  logic [127:0]        s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                s_tlast,
    output logic [39:0]         m_tdata,
    output logic [2:0]          m_tuser,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  shgb_pkg::op_t       op,
    output shgb_pkg::stat_t     stat
);

    localparam int IW = shgb_pkg::IDX_W;
    localparam int CW = shgb_pkg::CNT_W;

    logic [CW-1:0]      pc_reg;
    logic [23:0]        inv_reg;
    shgb_pkg::action_t  act_reg;
    logic               last_reg;
    logic [23:0]        px_reg, py_reg;
    logic [31:0]        cx_reg, cy_reg, pa_reg;
    logic [IW-1:0]      e_reg, h_reg;
    logic [47:0]        prod_reg;
    logic [CW-1:0]      loaded_reg, built_reg, i_reg, j_reg, sum_reg;
    logic [CW-1:0]      rs_res_reg, re_res_reg, rs_out_reg, re_out_reg;
    logic [IW-1:0]      pidx_res_reg, pidx_out_reg;
    logic [1:0]         st_res_reg, st_out_reg;
    logic               done_res_reg, done_out_reg;
    logic               out_valid_reg;

    logic [CW-1:0]      n;
    logic [23:0]        mag_x, mag_y;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        product;

    logic               div_start, div_busy, div_done;
    logic [31:0]        div_dividend;
    logic [IW-1:0]      rem;

    logic [IW-1:0]      hash_mem [0:shgb_pkg::MAX_PARTICLES-1];
    logic [CW-1:0]      bkt_mem  [0:shgb_pkg::MAX_PARTICLES];
    logic [IW-1:0]      ent_mem  [0:shgb_pkg::MAX_PARTICLES-1];

    logic               hs_we, hs_re, bk_we, bk_re, en_we, en_re;
    logic [IW-1:0]      hs_waddr, hs_wdata, hs_raddr, en_waddr, en_wdata, en_raddr;
    logic [CW-1:0]      bk_waddr, bk_wdata, bk_raddr;
    logic [IW-1:0]      hs_rd_reg, en_rd_reg;
    logic [CW-1:0]      bk_rd_reg;

    logic [CW-1:0]      bk_inc, bk_dec, pre_sum;

    function automatic logic [31:0] cell_of(input logic [47:0] p, input logic neg);
        logic [24:0] c;
        c = {1'b0, p[47:24]} + {24'd0, (p[23:0] != 24'd0)};
        if (neg)
            cell_of = 32'd0 - {7'd0, c};
        else
            cell_of = {8'd0, p[47:24]};
    endfunction

    assign n = (pc_reg == '0) ? CW'(1)
             : ((pc_reg > shgb_pkg::BKT_LAST) ? shgb_pkg::BKT_LAST : pc_reg);

    assign mag_x   = px_reg[23] ? (24'd0 - px_reg) : px_reg;
    assign mag_y   = py_reg[23] ? (24'd0 - py_reg) : py_reg;
    assign product = {32'd0, mul_a} * {32'd0, mul_b};
    assign bk_inc  = bk_rd_reg + CW'(1);
    assign bk_dec  = bk_rd_reg - CW'(1);
    assign pre_sum = sum_reg + bk_rd_reg;

    shgb_mod_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (n),
        .busy     (div_busy),
        .done     (div_done),
        .rem      (rem)
    );

    always_comb
    begin
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        hs_we = 1'b0; hs_waddr = '0; hs_wdata = '0; hs_re = 1'b0; hs_raddr = '0;
        bk_we = 1'b0; bk_waddr = '0; bk_wdata = '0; bk_re = 1'b0; bk_raddr = '0;
        en_we = 1'b0; en_waddr = '0; en_wdata = '0; en_re = 1'b0; en_raddr = '0;
        unique case (op)
            shgb_pkg::OP_MUL_X:
            begin
                mul_a = {8'd0, mag_x};
                mul_b = {8'd0, inv_reg};
            end
            shgb_pkg::OP_MUL_Y:
            begin
                mul_a = {8'd0, mag_y};
                mul_b = {8'd0, inv_reg};
            end
            shgb_pkg::OP_MUL_A:
            begin
                mul_a = cx_reg;
                mul_b = shgb_pkg::HASH_A;
            end
            shgb_pkg::OP_MUL_B:
            begin
                mul_a = cy_reg;
                mul_b = shgb_pkg::HASH_B;
            end
            shgb_pkg::OP_HASH:
            begin
                div_start    = 1'b1;
                div_dividend = pa_reg ^ prod_reg[31:0];
            end
            shgb_pkg::OP_STORE:
            begin
                hs_we    = 1'b1;
                hs_waddr = loaded_reg[IW-1:0];
                hs_wdata = rem;
            end
            shgb_pkg::OP_Q_RD0:
            begin
                bk_re    = 1'b1;
                bk_raddr = {1'b0, rem};
            end
            shgb_pkg::OP_Q_RD1:
            begin
                bk_re    = 1'b1;
                bk_raddr = {1'b0, rem} + CW'(1);
            end
            shgb_pkg::OP_E_RD:
            begin
                en_re    = 1'b1;
                en_raddr = e_reg;
            end
            shgb_pkg::OP_CLR:
            begin
                bk_we    = 1'b1;
                bk_waddr = j_reg;
                bk_wdata = '0;
            end
            shgb_pkg::OP_CNT_RD,
            shgb_pkg::OP_SC_RD:
            begin
                hs_re    = 1'b1;
                hs_raddr = i_reg[IW-1:0];
            end
            shgb_pkg::OP_CNT_DIV:
            begin
                div_start    = 1'b1;
                div_dividend = {20'd0, hs_rd_reg};
            end
            shgb_pkg::OP_CNT_BRD:
            begin
                hs_we    = 1'b1;
                hs_waddr = i_reg[IW-1:0];
                hs_wdata = rem;
                bk_re    = 1'b1;
                bk_raddr = {1'b0, rem};
            end
            shgb_pkg::OP_CNT_BWR:
            begin
                bk_we    = 1'b1;
                bk_waddr = {1'b0, rem};
                bk_wdata = bk_inc;
            end
            shgb_pkg::OP_PRE_RD:
            begin
                bk_re    = 1'b1;
                bk_raddr = j_reg;
            end
            shgb_pkg::OP_PRE_WR:
            begin
                bk_we    = 1'b1;
                bk_waddr = j_reg;
                bk_wdata = pre_sum;
            end
            shgb_pkg::OP_SC_BRD:
            begin
                bk_re    = 1'b1;
                bk_raddr = {1'b0, hs_rd_reg};
            end
            shgb_pkg::OP_SC_WR:
            begin
                bk_we    = 1'b1;
                bk_waddr = {1'b0, h_reg};
                bk_wdata = bk_dec;
                en_we    = 1'b1;
                en_waddr = bk_dec[IW-1:0];
                en_wdata = i_reg[IW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (hs_we)
            hash_mem[hs_waddr] <= hs_wdata;
        if (hs_re)
            hs_rd_reg <= hash_mem[hs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (bk_we)
            bkt_mem[bk_waddr] <= bk_wdata;
        if (bk_re)
            bk_rd_reg <= bkt_mem[bk_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (en_we)
            ent_mem[en_waddr] <= en_wdata;
        if (en_re)
            en_rd_reg <= ent_mem[en_raddr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= shgb_pkg::BKT_LAST;
            inv_reg       <= 24'd65536;
            loaded_reg    <= '0;
            built_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    shgb_pkg::CFG_PCOUNT: pc_reg  <= cfg_wdata[CW-1:0];
                    shgb_pkg::CFG_INV:    inv_reg <= cfg_wdata;
                    default:              ;
                endcase
            end
            if (op == shgb_pkg::OP_OUT)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            unique case (op)
                shgb_pkg::OP_STORE:   loaded_reg <= loaded_reg + CW'(1);
                shgb_pkg::OP_CLR:
                begin
                    j_reg <= (j_reg == shgb_pkg::BKT_LAST) ? '0 : j_reg + CW'(1);
                    i_reg <= '0;
                end
                shgb_pkg::OP_CNT_BWR: i_reg <= i_reg + CW'(1);
                shgb_pkg::OP_PRE_WR:
                begin
                    j_reg <= j_reg + CW'(1);
                    i_reg <= '0;
                end
                shgb_pkg::OP_SC_WR:   i_reg <= i_reg + CW'(1);
                shgb_pkg::OP_BUILT:
                begin
                    built_reg  <= loaded_reg;
                    loaded_reg <= '0;
                    j_reg      <= '0;
                end
                default:              ;
            endcase
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        prod_reg <= product[47:0];
        unique case (op)
            shgb_pkg::OP_CAPTURE:
            begin
                act_reg      <= shgb_pkg::action_t'(s_tuser);
                last_reg     <= s_tlast;
                px_reg       <= s_tdata[23:0];
                py_reg       <= s_tdata[47:24];
                cx_reg       <= s_tdata[79:48];
                cy_reg       <= s_tdata[111:80];
                e_reg        <= s_tdata[123:112];
                rs_res_reg   <= '0;
                re_res_reg   <= '0;
                pidx_res_reg <= '0;
                done_res_reg <= 1'b0;
                st_res_reg   <= (shgb_pkg::action_t'(s_tuser) == shgb_pkg::ACT_LOAD
                                 && loaded_reg >= n) ? shgb_pkg::STAT_LONG
                                                     : shgb_pkg::STAT_OK;
            end
            shgb_pkg::OP_MUL_Y: cx_reg <= cell_of(prod_reg, px_reg[23]);
            shgb_pkg::OP_MUL_A:
            begin
                if (act_reg == shgb_pkg::ACT_LOAD)
                    cy_reg <= cell_of(prod_reg, py_reg[23]);
            end
            shgb_pkg::OP_MUL_B: pa_reg <= prod_reg[31:0];
            shgb_pkg::OP_STORE:
            begin
                if (last_reg && (loaded_reg + CW'(1)) < n)
                    st_res_reg <= shgb_pkg::STAT_SHORT;
            end
            shgb_pkg::OP_Q_RD1: rs_res_reg <= bk_rd_reg;
            shgb_pkg::OP_Q_FIN: re_res_reg <= bk_rd_reg;
            shgb_pkg::OP_E_FIN:
            begin
                if ({1'b0, e_reg} < built_reg)
                    pidx_res_reg <= en_rd_reg;
                else
                    st_res_reg <= shgb_pkg::STAT_RANGE;
            end
            shgb_pkg::OP_CLR:    sum_reg <= '0;
            shgb_pkg::OP_PRE_WR: sum_reg <= pre_sum;
            shgb_pkg::OP_SC_BRD: h_reg <= hs_rd_reg;
            shgb_pkg::OP_BUILT:  done_res_reg <= 1'b1;
            shgb_pkg::OP_OUT:
            begin
                rs_out_reg   <= rs_res_reg;
                re_out_reg   <= re_res_reg;
                pidx_out_reg <= pidx_res_reg;
                st_out_reg   <= st_res_reg;
                done_out_reg <= done_res_reg;
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, pidx_out_reg, re_out_reg, rs_out_reg};
    assign m_tuser  = {done_out_reg, st_out_reg};

    assign stat.div_done  = div_done;
    assign stat.load_full = loaded_reg >= n;
    assign stat.in_last   = s_tlast;
    assign stat.in_act    = shgb_pkg::action_t'(s_tuser);
    assign stat.item_last = last_reg;
    assign stat.item_act  = act_reg;
    assign stat.clr_last  = j_reg == shgb_pkg::BKT_LAST;
    assign stat.cnt_empty = loaded_reg == '0;
    assign stat.cnt_last  = (i_reg + CW'(1)) == loaded_reg;
    assign stat.pre_last  = j_reg == n;
    assign stat.out_busy  = out_valid_reg && !m_tready;

    `SHGB_ASSERT_IMPL(a_div_no_restart, div_start, !div_busy, "remainder unit restarted while busy")
    `SHGB_ASSERT_IMPL(a_loaded_bound, 1'b1, loaded_reg <= shgb_pkg::BKT_LAST, "load count overflow")
    `SHGB_ASSERT_IMPL(a_out_no_overwrite, op == shgb_pkg::OP_OUT, !(out_valid_reg && !m_tready), "result overwritten while stalled")
    `SHGB_ASSERT_NEXT(a_built_clears, op == shgb_pkg::OP_BUILT, loaded_reg == '0 && done_res_reg, "rebuild end not recorded")

endmodule

`default_nettype wire

### rtl/core/shgb_ctrl.sv
// Controller state machine: sequences loads, queries, reads, table clear and rebuild.
// Depends on shgb_pkg.
`default_nettype none

module shgb_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  shgb_pkg::stat_t  stat,
    output shgb_pkg::op_t    op
);

    typedef enum logic [25:0] {
        ST_CLEAR   = 26'd1 << 0,
        ST_IDLE    = 26'd1 << 1,
        ST_MX      = 26'd1 << 2,
        ST_MY      = 26'd1 << 3,
        ST_MA      = 26'd1 << 4,
        ST_MB      = 26'd1 << 5,
        ST_HASH    = 26'd1 << 6,
        ST_DIV     = 26'd1 << 7,
        ST_STORE   = 26'd1 << 8,
        ST_QRD0    = 26'd1 << 9,
        ST_QRD1    = 26'd1 << 10,
        ST_QFIN    = 26'd1 << 11,
        ST_ERD     = 26'd1 << 12,
        ST_EFIN    = 26'd1 << 13,
        ST_CNT_RD  = 26'd1 << 14,
        ST_CNT_DIV = 26'd1 << 15,
        ST_CNT_WT  = 26'd1 << 16,
        ST_CNT_BRD = 26'd1 << 17,
        ST_CNT_BWR = 26'd1 << 18,
        ST_PRE_RD  = 26'd1 << 19,
        ST_PRE_WR  = 26'd1 << 20,
        ST_SC_RD   = 26'd1 << 21,
        ST_SC_BRD  = 26'd1 << 22,
        ST_SC_WR   = 26'd1 << 23,
        ST_FIN     = 26'd1 << 24,
        ST_OUT     = 26'd1 << 25
    } state_t;

    state_t state_reg, state_next;
    logic   rebuild_reg, rebuild_next;

    always_comb
    begin
        state_next   = state_reg;
        rebuild_next = rebuild_reg;
        op           = shgb_pkg::OP_NOP;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                op = shgb_pkg::OP_CLR;
                if (stat.clr_last)
                begin
                    rebuild_next = 1'b0;
                    if (!rebuild_reg)
                        state_next = ST_IDLE;
                    else if (stat.cnt_empty)
                        state_next = ST_PRE_RD;
                    else
                        state_next = ST_CNT_RD;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op = shgb_pkg::OP_CAPTURE;
                    unique case (stat.in_act)
                        shgb_pkg::ACT_LOAD:
                        begin
                            if (!stat.load_full)
                                state_next = ST_MX;
                            else if (stat.in_last)
                            begin
                                state_next   = ST_CLEAR;
                                rebuild_next = 1'b1;
                            end
                            else
                                state_next = ST_OUT;
                        end
                        shgb_pkg::ACT_QUERY: state_next = ST_MA;
                        shgb_pkg::ACT_READ:  state_next = ST_ERD;
                        default:             state_next = ST_OUT;
                    endcase
                end
            end
            ST_MX:
            begin
                op         = shgb_pkg::OP_MUL_X;
                state_next = ST_MY;
            end
            ST_MY:
            begin
                op         = shgb_pkg::OP_MUL_Y;
                state_next = ST_MA;
            end
            ST_MA:
            begin
                op         = shgb_pkg::OP_MUL_A;
                state_next = ST_MB;
            end
            ST_MB:
            begin
                op         = shgb_pkg::OP_MUL_B;
                state_next = ST_HASH;
            end
            ST_HASH:
            begin
                op         = shgb_pkg::OP_HASH;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (stat.div_done)
                    state_next = (stat.item_act == shgb_pkg::ACT_LOAD) ? ST_STORE : ST_QRD0;
            end
            ST_STORE:
            begin
                op = shgb_pkg::OP_STORE;
                if (stat.item_last)
                begin
                    state_next   = ST_CLEAR;
                    rebuild_next = 1'b1;
                end
                else
                    state_next = ST_OUT;
            end
            ST_QRD0:
            begin
                op         = shgb_pkg::OP_Q_RD0;
                state_next = ST_QRD1;
            end
            ST_QRD1:
            begin
                op         = shgb_pkg::OP_Q_RD1;
                state_next = ST_QFIN;
            end
            ST_QFIN:
            begin
                op         = shgb_pkg::OP_Q_FIN;
                state_next = ST_OUT;
            end
            ST_ERD:
            begin
                op         = shgb_pkg::OP_E_RD;
                state_next = ST_EFIN;
            end
            ST_EFIN:
            begin
                op         = shgb_pkg::OP_E_FIN;
                state_next = ST_OUT;
            end
            ST_CNT_RD:
            begin
                op         = shgb_pkg::OP_CNT_RD;
                state_next = ST_CNT_DIV;
            end
            ST_CNT_DIV:
            begin
                op         = shgb_pkg::OP_CNT_DIV;
                state_next = ST_CNT_WT;
            end
            ST_CNT_WT:
            begin
                if (stat.div_done)
                    state_next = ST_CNT_BRD;
            end
            ST_CNT_BRD:
            begin
                op         = shgb_pkg::OP_CNT_BRD;
                state_next = ST_CNT_BWR;
            end
            ST_CNT_BWR:
            begin
                op         = shgb_pkg::OP_CNT_BWR;
                state_next = stat.cnt_last ? ST_PRE_RD : ST_CNT_RD;
            end
            ST_PRE_RD:
            begin
                op         = shgb_pkg::OP_PRE_RD;
                state_next = ST_PRE_WR;
            end
            ST_PRE_WR:
            begin
                op = shgb_pkg::OP_PRE_WR;
                if (stat.pre_last)
                    state_next = stat.cnt_empty ? ST_FIN : ST_SC_RD;
                else
                    state_next = ST_PRE_RD;
            end
            ST_SC_RD:
            begin
                op         = shgb_pkg::OP_SC_RD;
                state_next = ST_SC_BRD;
            end
            ST_SC_BRD:
            begin
                op         = shgb_pkg::OP_SC_BRD;
                state_next = ST_SC_WR;
            end
            ST_SC_WR:
            begin
                op         = shgb_pkg::OP_SC_WR;
                state_next = stat.cnt_last ? ST_FIN : ST_SC_RD;
            end
            ST_FIN:
            begin
                op         = shgb_pkg::OP_BUILT;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!stat.out_busy)
                begin
                    op         = shgb_pkg::OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            rebuild_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rebuild_reg <= rebuild_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/spatial_hash_grid_builder.sv
// Top level of the spatial hash grid builder: controller plus datapath.
// Depends on shgb_pkg, shgb_ctrl and shgb_datapath.
//
// One item is worked at a time. A load makes four passes through the shared
// 32x32 multiplier, then runs the 32-step remainder unit; a query makes two
// multiplier passes and two bucket reads; a read makes one read of the entry
// store. A load that closes a frame also rebuilds the table: it clears the
// bucket memory, then runs a count pass that uses the remainder unit for each
// particle, a prefix sum over the buckets and a scatter of the particles, all
// limited by the single read port of each memory. After reset the bucket
// memory is cleared while s_tready stays low; configuration writes are taken.
// A finished result waits in the output register.
`default_nettype none

module spatial_hash_grid_builder (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [23:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // pos_x, pos_y, cell_x, cell_y, entry_index, zero pad
    input  logic [1:0]   s_tuser,   // action
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [39:0]  m_tdata,   // range_start, range_end, particle_index, zero pad
    output logic [2:0]   m_tuser    // status, build_done
);

    shgb_pkg::op_t   op;
    shgb_pkg::stat_t stat;

    shgb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .op       (op)
    );

    shgb_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .op        (op),
        .stat      (stat)
    );

endmodule

`default_nettype wire

### dv/spatial_hash_grid_builder_tb.sv
// Self-checking testbench for spatial_hash_grid_builder: loads, rebuilds, queries and reads.
// A local predictor of the hash grid computes each result; random gaps on both stream sides.
// Depends on shgb_pkg and the RTL of spatial_hash_grid_builder.
`default_nettype none

module spatial_hash_grid_builder_tb;

    localparam int WATCHDOG_LIMIT = 60000;

    typedef struct packed {
        logic [12:0] range_start;
        logic [12:0] range_end;
        logic [11:0] particle_index;
        logic [1:0]  status;
        logic        build_done;
    } grid_result_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_we;
    logic [0:0]   cfg_index;
    logic [23:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         s_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic [39:0]  m_tdata;
    logic [2:0]   m_tuser;

    // grid model
    logic [12:0]  pcount_reg;
    logic [23:0]  inv_reg;
    logic [11:0]  hash_mem [shgb_pkg::MAX_PARTICLES];
    logic [12:0]  bucket_mem [shgb_pkg::MAX_PARTICLES+1];
    logic [11:0]  entry_mem [shgb_pkg::MAX_PARTICLES];
    int unsigned  loaded_cnt;
    int unsigned  built_cnt;

    grid_result_t expected_q [$];
    int           errors;
    int           idle_cycles;
    int           stall_left;
    bit           quiet;
    int           n_load, n_query, n_read, n_frame, n_result;

    spatial_hash_grid_builder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int unsigned bucket_modulus();
        int unsigned n;
        n = pcount_reg;
        if (n == 0) n = 1;
        if (n > shgb_pkg::MAX_PARTICLES) n = shgb_pkg::MAX_PARTICLES;
        return n;
    endfunction

    // floor(pos * inv), pos Q.8 signed, inv Q.16 unsigned
    function automatic logic [31:0] grid_cell(logic [23:0] pos);
        logic [24:0] mag;
        logic [63:0] prod;
        mag  = pos[23] ? (25'h1000000 - {1'b0, pos}) : {1'b0, pos};
        prod = 64'(mag) * 64'(inv_reg);
        if (!pos[23]) return prod[55:24];
        prod = prod + 64'hFFFFFF;
        return 32'd0 - prod[55:24];
    endfunction

    function automatic logic [31:0] cell_hash(logic [31:0] cx, logic [31:0] cy,
                                              int unsigned n);
        logic [31:0] raw;
        raw = (cx * shgb_pkg::HASH_A) ^ (cy * shgb_pkg::HASH_B);
        return raw % n;
    endfunction

    task automatic rebuild_grid(int unsigned n);
        int unsigned sum;
        int unsigned h;
        sum = 0;
        for (int i = 0; i <= shgb_pkg::MAX_PARTICLES; i++) bucket_mem[i] = '0;
        for (int unsigned i = 0; i < loaded_cnt; i++)
            bucket_mem[hash_mem[i] % n] = bucket_mem[hash_mem[i] % n] + 1;
        for (int unsigned i = 0; i <= n; i++)
        begin
            sum = sum + bucket_mem[i];
            bucket_mem[i] = sum;
        end
        for (int unsigned i = 0; i < loaded_cnt; i++)
        begin
            h = hash_mem[i] % n;
            bucket_mem[h] = bucket_mem[h] - 1;
            entry_mem[bucket_mem[h] % shgb_pkg::MAX_PARTICLES] = i;
        end
        built_cnt  = loaded_cnt;
        loaded_cnt = 0;
    endtask

    task automatic predict_grid(shgb_pkg::action_t act, logic [23:0] px, logic [23:0] py,
                                logic last, logic [31:0] cx, logic [31:0] cy,
                                logic [11:0] ei);
        grid_result_t r;
        int unsigned  n;
        logic [31:0]  h;
        r = '0;
        n = bucket_modulus();
        case (act)
            shgb_pkg::ACT_LOAD:
            begin
                n_load++;
                if (loaded_cnt < n)
                begin
                    hash_mem[loaded_cnt] = cell_hash(grid_cell(px), grid_cell(py), n);
                    loaded_cnt++;
                end
                else
                    r.status = shgb_pkg::STAT_LONG;
                if (last)
                begin
                    if (r.status == shgb_pkg::STAT_OK && loaded_cnt < n)
                        r.status = shgb_pkg::STAT_SHORT;
                    rebuild_grid(n);
                    r.build_done = 1'b1;
                    n_frame++;
                end
            end
            shgb_pkg::ACT_QUERY:
            begin
                n_query++;
                h = cell_hash(cx, cy, n);
                r.range_start = bucket_mem[h];
                r.range_end   = bucket_mem[h+1];
            end
            shgb_pkg::ACT_READ:
            begin
                n_read++;
                if (ei < built_cnt) r.particle_index = entry_mem[ei];
                else r.status = shgb_pkg::STAT_RANGE;
            end
            default: ;
        endcase
        expected_q.push_back(r);
    endtask

    function automatic int rand_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic send_item(shgb_pkg::action_t act, logic [23:0] px, logic [23:0] py,
                             logic last, logic [31:0] cx, logic [31:0] cy,
                             logic [11:0] ei);
        int gap;
        gap = rand_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tlast  <= last;
        s_tdata  <= {4'd0, ei, cy, cx, py, px};
        do @(posedge clk); while (!s_tready);
        predict_grid(act, px, py, last, cx, cy, ei);
    endtask

    task automatic load(logic [23:0] px, logic [23:0] py, logic last);
        send_item(shgb_pkg::ACT_LOAD, px, py, last, $urandom, $urandom, $urandom);
    endtask

    task automatic query(logic [31:0] cx, logic [31:0] cy);
        send_item(shgb_pkg::ACT_QUERY, $urandom, $urandom, $urandom, cx, cy, $urandom);
    endtask

    task automatic read_entry(logic [11:0] ei);
        send_item(shgb_pkg::ACT_READ, $urandom, $urandom, $urandom, $urandom, $urandom, ei);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == shgb_pkg::CFG_PCOUNT) pcount_reg = val[12:0];
        else inv_reg = val;
    endtask

    task automatic reconfigure(logic [12:0] pcount, logic [23:0] inv);
        wait_idle();
        write_reg(shgb_pkg::CFG_PCOUNT, 24'(pcount));
        write_reg(shgb_pkg::CFG_INV, inv);
    endtask

    // random position: full range or near the origin
    function automatic logic [23:0] rand_pos();
        if ($urandom_range(1)) return $urandom;
        return 24'($signed($urandom_range(2047)) - 1024);
    endfunction

    function automatic logic [31:0] rand_cell();
        if ($urandom_range(3) == 0) return $urandom;
        return 32'($signed($urandom_range(15)) - 8);
    endfunction

    task automatic test_reset_state();
        query(32'd0, 32'd0);
        query(32'h8000_0000, 32'h7FFF_FFFF);
        read_entry(12'd0);
        send_item(shgb_pkg::ACT_NONE, 24'hFFFFFF, 24'hFFFFFF, 1'b1, '1, '1, '1);
    endtask

    task automatic test_position_extremes();
        reconfigure(13'd5, 24'hFFFFFF);
        load(24'h800000, 24'h7FFFFF, 1'b0);
        load(24'h7FFFFF, 24'h800000, 1'b0);
        load(24'h000000, 24'hFFFFFF, 1'b0);
        load(24'h000001, 24'h800001, 1'b0);
        load(24'hFFFFFF, 24'h000100, 1'b1);
        for (int i = 0; i < 6; i++) read_entry(12'(i));
        read_entry(12'hFFF);
        query(32'h8000_0000, 32'hFFFF_FFFF);
        query(32'h7FFF_FFFF, 32'd0);
    endtask

    task automatic test_zero_inverse();
        reconfigure(13'd3, 24'd0);
        load(24'h123456, 24'h876543, 1'b0);
        load(24'h7FFFFF, 24'h800000, 1'b0);
        load(24'h000000, 24'h000000, 1'b1);
        query(32'd0, 32'd0);
        read_entry(12'd2);
    endtask

    task automatic test_frame_length();
        reconfigure(13'd2, 24'd1);
        load(24'h000100, 24'h000200, 1'b0);
        load(24'h000300, 24'h000400, 1'b0);
        load(24'h000500, 24'h000600, 1'b0);
        load(24'h000700, 24'h000800, 1'b1);
        read_entry(12'd1);
        read_entry(12'd2);
        load(24'h000100, 24'h000100, 1'b1);
        read_entry(12'd0);
        read_entry(12'd1);
    endtask

    task automatic test_modulus_limits();
        reconfigure(13'd0, 24'd65536);
        load(24'h001000, 24'h002000, 1'b1);
        query(32'd16, 32'd32);
        reconfigure(13'd4096, 24'd65536);
        load(24'h001000, 24'h002000, 1'b1);
        query(32'd16, 32'd32);
        query(32'hFFFF_FFFF, 32'h8000_0000);
        reconfigure(13'h1FFF, 24'd12345);
        load(24'hF00000, 24'h0F0000, 1'b1);
        read_entry(12'd0);
        // shrink the modulus in the middle of a frame
        reconfigure(13'd7, 24'd100000);
        load(24'h012345, 24'hFEDCBA, 1'b0);
        load(24'h234567, 24'h765432, 1'b0);
        load(24'h3A3A3A, 24'hC5C5C5, 1'b0);
        reconfigure(13'd3, 24'd100000);
        load(24'h000000, 24'h000000, 1'b1);
        query(32'd0, 32'd0);
        read_entry(12'd2);
    endtask

    task automatic test_random_frames();
        int unsigned n;
        int          k;
        int          r;
        while (n_load + n_query + n_read < 650)
        begin
            quiet = ($urandom_range(4) == 0);
            r = $urandom_range(19);
            if (r == 0) n = $urandom_range(8191, 4097);
            else if (r == 1) n = 0;
            else n = $urandom_range(12, 1);
            reconfigure(13'(n), ($urandom_range(9) == 0) ? 24'(0) : 24'($urandom));
            n = bucket_modulus();
            r = $urandom_range(9);
            if (n > 64) k = $urandom_range(6, 1);
            else if (r < 6) k = n;
            else if (r < 8) k = (n > 1) ? $urandom_range(n - 1, 1) : 1;
            else k = n + $urandom_range(3, 1);
            for (int i = 0; i < k; i++)
            begin
                if ($urandom_range(7) == 0) query(rand_cell(), rand_cell());
                if ($urandom_range(15) == 0)
                    send_item(shgb_pkg::ACT_NONE, $urandom, $urandom, $urandom, $urandom,
                              $urandom, $urandom);
                if (i == k / 2 && $urandom_range(9) == 0)
                    reconfigure(13'($urandom_range(12, 1)), inv_reg);
                load(rand_pos(), rand_pos(), i == k - 1);
            end
            repeat ($urandom_range(8, 2))
            begin
                if ($urandom_range(1)) query(rand_cell(), rand_cell());
                else read_entry(12'($urandom_range(built_cnt + 2)));
            end
        end
        quiet = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (quiet)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(9) < 2)
                stall_left <= ($urandom_range(9) == 0) ? $urandom_range(60, 10)
                                                       : $urandom_range(3, 1);
        end
    end

    always @(posedge clk)
    begin
        grid_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_result++;
            if (expected_q.size() == 0)
            begin
                $error("result transfer with no expectation pending");
                errors++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (m_tdata[12:0] !== want.range_start)
                begin
                    $error("range_start exp %0d got %0d", want.range_start, m_tdata[12:0]);
                    errors++;
                end
                if (m_tdata[25:13] !== want.range_end)
                begin
                    $error("range_end exp %0d got %0d", want.range_end, m_tdata[25:13]);
                    errors++;
                end
                if (m_tdata[37:26] !== want.particle_index)
                begin
                    $error("particle_index exp %0d got %0d", want.particle_index,
                           m_tdata[37:26]);
                    errors++;
                end
                if (m_tuser[1:0] !== want.status)
                begin
                    $error("status exp %0d got %0d", want.status, m_tuser[1:0]);
                    errors++;
                end
                if (m_tuser[2] !== want.build_done)
                begin
                    $error("build_done exp %0d got %0d", want.build_done, m_tuser[2]);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer in %0d cycles, %0d results pending",
                     WATCHDOG_LIMIT, expected_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        s_tlast    = 1'b0;
        errors     = 0;
        idle_cycles = 0;
        quiet      = 1'b0;
        n_load = 0; n_query = 0; n_read = 0; n_frame = 0; n_result = 0;
        pcount_reg = 13'd4096;
        inv_reg    = 24'd65536;
        loaded_cnt = 0;
        built_cnt  = 0;
        for (int i = 0; i <= shgb_pkg::MAX_PARTICLES; i++) bucket_mem[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_position_extremes();
        test_zero_inverse();
        test_frame_length();
        test_modulus_limits();
        test_random_frames();

        wait_idle();
        $display("covered %0d loads in %0d rebuilt frames, %0d queries, %0d reads",
                 n_load, n_frame, n_query, n_read);
        $display("%0d results checked, %0d mismatches", n_result, errors);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl/core
rtl/core/shgb_pkg.sv
rtl/core/shgb_mod_div.sv
rtl/core/shgb_datapath.sv
rtl/core/shgb_ctrl.sv
rtl/core/spatial_hash_grid_builder.sv
dv/spatial_hash_grid_builder_tb.sv
